@@ hdl/bsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, constants and saturating Q32.32 helpers for the scalar
// minimiser: payload structs, datapath operation codes, operand selects.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int WORD_BITS = 64;
  localparam int FRAC_BITS = 32;
  localparam int EPS_SHIFT = 26;
  localparam int TOL_BITS  = 33;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

  typedef logic signed [WORD_BITS-1:0] q_t;
  typedef logic [WORD_BITS-1:0] qmag_t;

  localparam q_t QMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam q_t QZERO = '0;
  // Golden-section constant (3 - sqrt 5) / 2, rounded at FRAC_BITS bits.
  localparam q_t GOLD = q_t'(64'h0000_0000_61C8_8647);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL_START = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL_END   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ABS_TOLERANCE  = 2'd2;

  localparam q_t CFG_START_RST = '0;
  localparam q_t CFG_END_RST   = q_t'(64'h0000_0001_0000_0000);
  localparam logic [TOL_BITS-1:0] CFG_TOL_RST = TOL_BITS'(4295);

  // Register file entries first, then read-only sources.
  localparam int NUM_RF = 20;
  typedef enum logic [4:0] {
    R_SA, R_SB, R_X, R_W, R_V, R_FX, R_FW, R_FV, R_D, R_E,
    R_U, R_M, R_TOL, R_T2, R_P, R_Q, R_R, R_T0, R_T1, R_T3,
    R_FU, R_CS, R_CE, R_CT, R_GOLD, R_ZERO
  } rsel_t;

  typedef enum logic [4:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_ABS, OP_HALF, OP_MID, OP_TOL, OP_SEL,
    OP_SELNEG, OP_LT, OP_LE, OP_MUL, OP_DIV, OP_START_CLR, OP_FIRST,
    OP_PQR_CLR, OP_UPDATE
  } dp_op_t;

  typedef struct packed {
    logic   valid;
    dp_op_t op;
    rsel_t  dst;
    rsel_t  src_a;
    rsel_t  src_b;
  } cmd_t;

  typedef struct packed {
    logic ack;
    logic cmp;
  } dp_status_t;

  typedef struct packed {
    logic load;
    logic done;
    logic use_u;
  } emit_t;

  typedef struct packed {
    logic opcode;
    q_t   func_value;
  } in_item_t;

  typedef struct packed {
    q_t   eval_point;
    logic done_res;
    q_t   best_point;
    q_t   best_value;
  } out_item_t;

  // Saturating add.
  function automatic q_t sat_add(q_t a, q_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? QMIN : QMAX;
    return s[WORD_BITS-1:0];
  endfunction

  // Saturating subtract.
  function automatic q_t sat_sub(q_t a, q_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? QMIN : QMAX;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic q_t sat_abs(q_t a);
    return a[WORD_BITS-1] ? sat_sub(QZERO, a) : a;
  endfunction

  // Signed halving, truncated toward zero.
  function automatic q_t q_half(q_t a);
    q_t t;
    t = a + q_t'(a[WORD_BITS-1]);
    return t >>> 1;
  endfunction

  // Midpoint without overflow.
  function automatic q_t q_mid(q_t a, q_t b);
    q_t corr;
    corr = '0;
    if (a[0] && b[0] && (a[WORD_BITS-1] == b[WORD_BITS-1]))
      corr = a[WORD_BITS-1] ? q_t'(-1) : q_t'(1);
    return q_half(a) + q_half(b) + corr;
  endfunction

  function automatic qmag_t q_mag(q_t a);
    return a[WORD_BITS-1] ? qmag_t'(-a) : qmag_t'(a);
  endfunction

  // Signed value from a magnitude, saturated.
  function automatic q_t q_from_mag(qmag_t m, logic neg);
    qmag_t lim;
    qmag_t mm;
    lim = {1'b1, {(WORD_BITS-1){1'b0}}};
    if (neg) begin
      mm = (m > lim) ? lim : m;
      return q_t'(-mm);
    end
    return m[WORD_BITS-1] ? QMAX : q_t'(m);
  endfunction

endpackage

@@ hdl/bsm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_datapath
// Search state, configuration registers, a one-operation ALU, a sequential
// multiplier built on one 32x32 product per cycle and a restoring divider.
// ----------------------------------------------------------------------------
module bsm_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bsm_pkg::WORD_BITS-1:0]     cfg_wdata,
  input  logic                              in_take,
  input  bsm_pkg::q_t                       in_fv,
  input  bsm_pkg::cmd_t                     cmd,
  input  bsm_pkg::emit_t                    emit,
  output bsm_pkg::dp_status_t               st,
  output bsm_pkg::out_item_t                res
);
  import bsm_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_EXEC, D_MUL, D_DIV} du_state_t;

  localparam int MUL_LAST = 5;
  localparam int HALF_W = WORD_BITS / 2;

  du_state_t du_r;
  q_t        rf_r [NUM_RF];
  q_t        fu_r;
  q_t        cfg_start_r;
  q_t        cfg_end_r;
  logic [TOL_BITS-1:0] cfg_tol_r;
  dp_op_t    op_r;
  rsel_t     dst_r;
  q_t        opa_r;
  q_t        opb_r;
  logic      flag_r;

  // Multiplier state.
  qmag_t                   ma_r;
  qmag_t                   mb_r;
  logic                    mneg_r;
  logic [2*WORD_BITS-1:0]  acc_r;
  logic [WORD_BITS-1:0]    pp_r;
  logic [1:0]              psh_r;
  logic [2:0]              mcnt_r;

  // Divider state.
  logic [DIV_STEPS-1:0]    dnum_r;
  qmag_t                   drem_r;
  qmag_t                   dden_r;
  logic                    dneg_r;
  logic [DIV_CNT_BITS-1:0] dcnt_r;

  logic [HALF_W-1:0]       mul_a_part;
  logic [HALF_W-1:0]       mul_b_part;
  logic [WORD_BITS-1:0]    mul_pp;
  logic [2*WORD_BITS-1:0]  acc_sum;
  q_t                      mul_res;
  logic [WORD_BITS:0]      div_t;
  logic                    div_ge;
  logic [WORD_BITS:0]      div_rem;
  q_t                      div_res;
  q_t                      alu_res;
  q_t                      x_v;
  q_t                      u_v;
  logic                    upd_better;
  logic                    upd_ult;
  logic                    upd_second;
  logic                    upd_third;

  // Operand source selection.
  function automatic q_t src_val(rsel_t s);
    q_t v;
    case (s)
      R_FU:    v = fu_r;
      R_CS:    v = cfg_start_r;
      R_CE:    v = cfg_end_r;
      R_CT:    v = q_t'(cfg_tol_r);
      R_GOLD:  v = GOLD;
      R_ZERO:  v = QZERO;
      default: v = rf_r[s];
    endcase
    return v;
  endfunction

  // One partial product per cycle, accumulated in the cycle after.
  assign mul_a_part = mcnt_r[1] ? ma_r[WORD_BITS-1:HALF_W] : ma_r[HALF_W-1:0];
  assign mul_b_part = mcnt_r[0] ? mb_r[WORD_BITS-1:HALF_W] : mb_r[HALF_W-1:0];
  assign mul_pp     = mul_a_part * mul_b_part;
  assign acc_sum    = acc_r + ({{WORD_BITS{1'b0}}, pp_r} << {psh_r, 5'b0});
  assign mul_res    = q_from_mag((|acc_r[2*WORD_BITS-1:WORD_BITS+FRAC_BITS]) ?
                                 {WORD_BITS{1'b1}} :
                                 acc_r[WORD_BITS+FRAC_BITS-1:FRAC_BITS], mneg_r);

  // Restoring division step: one quotient bit a cycle.
  assign div_t   = {drem_r, dnum_r[DIV_STEPS-1]};
  assign div_ge  = div_t >= {1'b0, dden_r};
  assign div_rem = div_ge ? (div_t - {1'b0, dden_r}) : div_t;
  assign div_res = q_from_mag((|dnum_r[DIV_STEPS-1:WORD_BITS]) ? {WORD_BITS{1'b1}} :
                              dnum_r[WORD_BITS-1:0], dneg_r);

  // ALU operations, combinational on the registered operands.
  always_comb begin
    case (op_r)
      OP_ADD:    alu_res = sat_add(opa_r, opb_r);
      OP_SUB:    alu_res = sat_sub(opa_r, opb_r);
      OP_ABS:    alu_res = sat_abs(opa_r);
      OP_HALF:   alu_res = q_half(opa_r);
      OP_MID:    alu_res = q_mid(opa_r, opb_r);
      OP_TOL:    alu_res = sat_add(q_t'(q_mag(opa_r) >> EPS_SHIFT), opb_r);
      OP_SEL:    alu_res = flag_r ? opa_r : opb_r;
      OP_SELNEG: alu_res = flag_r ? opa_r : sat_sub(QZERO, opa_r);
      default:   alu_res = opa_r;
    endcase
  end

  // Bracket and best-three update after a new objective value.
  assign x_v        = rf_r[R_X];
  assign u_v        = rf_r[R_U];
  assign upd_better = fu_r <= rf_r[R_FX];
  assign upd_ult    = u_v < x_v;
  assign upd_second = (fu_r <= rf_r[R_FW]) || (rf_r[R_W] == x_v);
  assign upd_third  = (fu_r <= rf_r[R_FV]) || (rf_r[R_V] == x_v) ||
                      (rf_r[R_V] == rf_r[R_W]);

  // Status back to the controller.
  always_comb begin
    case (du_r)
      D_EXEC:  st.ack = !((op_r == OP_MUL) || ((op_r == OP_DIV) && (opb_r != QZERO)));
      D_MUL:   st.ack = (mcnt_r == 3'(MUL_LAST));
      D_DIV:   st.ack = (dcnt_r == DIV_CNT_BITS'(DIV_STEPS));
      default: st.ack = 1'b0;
    endcase
    st.cmp = (op_r == OP_LT) ? (opa_r < opb_r) : (opa_r <= opb_r);
  end

  // Result payload.
  always_comb begin
    res.eval_point = emit.use_u ? u_v : x_v;
    res.done_res   = emit.done;
    res.best_point = x_v;
    res.best_value = rf_r[R_FX];
  end

  // Sequencing of the operation units and all register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      du_r        <= D_IDLE;
      flag_r      <= 1'b0;
      cfg_start_r <= CFG_START_RST;
      cfg_end_r   <= CFG_END_RST;
      cfg_tol_r   <= CFG_TOL_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INTERVAL_START) cfg_start_r <= q_t'(cfg_wdata);
        if (cfg_index == CFG_INTERVAL_END)   cfg_end_r   <= q_t'(cfg_wdata);
        if (cfg_index == CFG_ABS_TOLERANCE)  cfg_tol_r   <= cfg_wdata[TOL_BITS-1:0];
      end
      if (in_take) fu_r <= in_fv;

      unique case (du_r)
        D_IDLE: begin
          if (cmd.valid) begin
            op_r  <= cmd.op;
            dst_r <= cmd.dst;
            opa_r <= src_val(cmd.src_a);
            opb_r <= src_val(cmd.src_b);
            du_r  <= D_EXEC;
          end
        end
        D_EXEC: begin
          du_r <= D_IDLE;
          case (op_r)
            OP_LT, OP_LE: flag_r <= st.cmp;
            OP_MUL: begin
              ma_r   <= q_mag(opa_r);
              mb_r   <= q_mag(opb_r);
              mneg_r <= opa_r[WORD_BITS-1] ^ opb_r[WORD_BITS-1];
              acc_r  <= '0;
              mcnt_r <= '0;
              du_r   <= D_MUL;
            end
            OP_DIV: begin
              if (opb_r == QZERO) begin
                rf_r[dst_r] <= opa_r[WORD_BITS-1] ? QMIN :
                               ((opa_r == QZERO) ? QZERO : QMAX);
              end else begin
                dnum_r <= {q_mag(opa_r), {FRAC_BITS{1'b0}}};
                drem_r <= '0;
                dden_r <= q_mag(opb_r);
                dneg_r <= opa_r[WORD_BITS-1] ^ opb_r[WORD_BITS-1];
                dcnt_r <= '0;
                du_r   <= D_DIV;
              end
            end
            OP_START_CLR: begin
              rf_r[R_W]  <= x_v;
              rf_r[R_V]  <= x_v;
              rf_r[R_U]  <= x_v;
              rf_r[R_FX] <= QZERO;
              rf_r[R_FW] <= QZERO;
              rf_r[R_FV] <= QZERO;
              rf_r[R_D]  <= QZERO;
              rf_r[R_E]  <= QZERO;
            end
            OP_FIRST: begin
              rf_r[R_FX] <= fu_r;
              rf_r[R_FW] <= fu_r;
              rf_r[R_FV] <= fu_r;
            end
            OP_PQR_CLR: begin
              rf_r[R_P] <= QZERO;
              rf_r[R_Q] <= QZERO;
              rf_r[R_R] <= QZERO;
            end
            OP_UPDATE: begin
              if (upd_better) begin
                if (upd_ult) rf_r[R_SB] <= x_v;
                else         rf_r[R_SA] <= x_v;
                rf_r[R_V]  <= rf_r[R_W];
                rf_r[R_FV] <= rf_r[R_FW];
                rf_r[R_W]  <= x_v;
                rf_r[R_FW] <= rf_r[R_FX];
                rf_r[R_X]  <= u_v;
                rf_r[R_FX] <= fu_r;
              end else begin
                if (upd_ult) rf_r[R_SA] <= u_v;
                else         rf_r[R_SB] <= u_v;
                if (upd_second) begin
                  rf_r[R_V]  <= rf_r[R_W];
                  rf_r[R_FV] <= rf_r[R_FW];
                  rf_r[R_W]  <= u_v;
                  rf_r[R_FW] <= fu_r;
                end else if (upd_third) begin
                  rf_r[R_V]  <= u_v;
                  rf_r[R_FV] <= fu_r;
                end
              end
            end
            default: rf_r[dst_r] <= alu_res;
          endcase
        end
        D_MUL: begin
          if (mcnt_r != 3'(MUL_LAST)) begin
            if (!mcnt_r[2]) begin
              pp_r  <= mul_pp;
              psh_r <= 2'(mcnt_r[1]) + 2'(mcnt_r[0]);
            end
            if (mcnt_r != 3'd0) acc_r <= acc_sum;
            mcnt_r <= mcnt_r + 3'd1;
          end else begin
            rf_r[dst_r] <= mul_res;
            du_r        <= D_IDLE;
          end
        end
        D_DIV: begin
          if (dcnt_r != DIV_CNT_BITS'(DIV_STEPS)) begin
            drem_r <= div_rem[WORD_BITS-1:0];
            dnum_r <= {dnum_r[DIV_STEPS-2:0], div_ge};
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            rf_r[dst_r] <= div_res;
            du_r        <= D_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ hdl/bsm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_ctrl
// Sequencer for the search: decodes each request, steps the datapath through the start
// or the update, stop test, parabolic fit and golden-section step, then emits.
// ----------------------------------------------------------------------------
module bsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  output logic                 in_ready,
  input  logic                 out_free,
  input  bsm_pkg::dp_status_t  st,
  output bsm_pkg::cmd_t        cmd,
  output bsm_pkg::emit_t       emit
);
  import bsm_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SEARCH, PH_DONE} phase_t;

  typedef enum logic [6:0] {
    ST_IDLE, ST_EMIT,
    ST_S_LOW, ST_S_HIGH, ST_S_SPAN, ST_S_GOLD, ST_S_X, ST_S_CLR,
    ST_V_FIRST, ST_V_UPD,
    ST_A_MID, ST_A_TOL, ST_A_T2, ST_A_XM, ST_A_XMA, ST_A_SPAN, ST_A_HALF,
    ST_A_LIM, ST_A_STOP, ST_A_CLR, ST_A_EABS, ST_A_ETST,
    ST_P_XW, ST_P_XV, ST_P_FV, ST_P_R, ST_P_FW, ST_P_Q, ST_P_XVQ, ST_P_XWR,
    ST_P_P, ST_P_QR, ST_P_QQ, ST_P_QPOS, ST_P_NEG, ST_P_QABS, ST_P_RE, ST_P_ED,
    ST_B_PABS, ST_B_QR, ST_B_HALF, ST_B_QRA, ST_B_T1, ST_B_SAX, ST_B_MLO,
    ST_B_T2, ST_B_SBX, ST_B_MHI, ST_B_T3, ST_B_DIV, ST_B_U, ST_B_UL, ST_B_T4,
    ST_B_UH, ST_B_T5, ST_B_SIDE, ST_B_SEL,
    ST_G_SB, ST_G_SA, ST_G_SIDE, ST_G_SEL, ST_G_D,
    ST_C_DABS, ST_C_TST, ST_C_UD, ST_C_UP, ST_C_UM, ST_C_SIGN, ST_C_SEL
  } state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   emit_done_r, emit_done_nxt;
  logic   emit_u_r, emit_u_nxt;
  state_t go;

  function automatic cmd_t mk(dp_op_t op, rsel_t d, rsel_t a, rsel_t b);
    cmd_t c;
    c.valid = 1'b1;
    c.op    = op;
    c.dst   = d;
    c.src_a = a;
    c.src_b = b;
    return c;
  endfunction

  assign in_ready   = (state_r == ST_IDLE);
  assign emit.load  = (state_r == ST_EMIT) && out_free;
  assign emit.done  = emit_done_r;
  assign emit.use_u = emit_u_r;

  // Command for each step and the step that follows it.
  always_comb begin
    cmd           = mk(OP_MOV, R_T0, R_ZERO, R_ZERO);
    cmd.valid     = 1'b0;
    go            = state_r;
    phase_nxt     = phase_r;
    emit_done_nxt = emit_done_r;
    emit_u_nxt    = emit_u_r;
    state_nxt     = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_opcode) begin
            state_nxt = ST_S_LOW;
          end else begin
            unique case (phase_r)
              PH_IDLE:   state_nxt = ST_IDLE;
              PH_FIRST:  state_nxt = ST_V_FIRST;
              PH_SEARCH: state_nxt = ST_V_UPD;
              PH_DONE: begin
                state_nxt     = ST_EMIT;
                emit_done_nxt = 1'b1;
                emit_u_nxt    = 1'b0;
              end
            endcase
          end
        end
      end
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;

      // Start of a search.
      ST_S_LOW:  begin cmd = mk(OP_MOV, R_SA, R_CS, R_ZERO); go = ST_S_HIGH; end
      ST_S_HIGH: begin cmd = mk(OP_MOV, R_SB, R_CE, R_ZERO); go = ST_S_SPAN; end
      ST_S_SPAN: begin cmd = mk(OP_SUB, R_T0, R_SB, R_SA); go = ST_S_GOLD; end
      ST_S_GOLD: begin cmd = mk(OP_MUL, R_T0, R_GOLD, R_T0); go = ST_S_X; end
      ST_S_X:    begin cmd = mk(OP_ADD, R_X, R_SA, R_T0); go = ST_S_CLR; end
      ST_S_CLR: begin
        cmd = mk(OP_START_CLR, R_X, R_ZERO, R_ZERO);
        go  = ST_EMIT;
        if (st.ack) begin
          phase_nxt     = PH_FIRST;
          emit_done_nxt = 1'b0;
          emit_u_nxt    = 1'b0;
        end
      end

      // New objective value.
      ST_V_FIRST: begin cmd = mk(OP_FIRST, R_FX, R_ZERO, R_ZERO); go = ST_A_MID; end
      ST_V_UPD:   begin cmd = mk(OP_UPDATE, R_X, R_ZERO, R_ZERO); go = ST_A_MID; end

      // Stop test.
      ST_A_MID:  begin cmd = mk(OP_MID, R_M, R_SA, R_SB); go = ST_A_TOL; end
      ST_A_TOL:  begin cmd = mk(OP_TOL, R_TOL, R_X, R_CT); go = ST_A_T2; end
      ST_A_T2:   begin cmd = mk(OP_ADD, R_T2, R_TOL, R_TOL); go = ST_A_XM; end
      ST_A_XM:   begin cmd = mk(OP_SUB, R_T0, R_X, R_M); go = ST_A_XMA; end
      ST_A_XMA:  begin cmd = mk(OP_ABS, R_T0, R_T0, R_ZERO); go = ST_A_SPAN; end
      ST_A_SPAN: begin cmd = mk(OP_SUB, R_T1, R_SB, R_SA); go = ST_A_HALF; end
      ST_A_HALF: begin cmd = mk(OP_HALF, R_T1, R_T1, R_ZERO); go = ST_A_LIM; end
      ST_A_LIM:  begin cmd = mk(OP_SUB, R_T1, R_T2, R_T1); go = ST_A_STOP; end
      ST_A_STOP: begin
        cmd = mk(OP_LE, R_T0, R_T0, R_T1);
        go  = st.cmp ? ST_EMIT : ST_A_CLR;
        if (st.ack && st.cmp) begin
          phase_nxt     = PH_DONE;
          emit_done_nxt = 1'b1;
          emit_u_nxt    = 1'b0;
        end
      end
      ST_A_CLR:  begin cmd = mk(OP_PQR_CLR, R_P, R_ZERO, R_ZERO); go = ST_A_EABS; end
      ST_A_EABS: begin cmd = mk(OP_ABS, R_T0, R_E, R_ZERO); go = ST_A_ETST; end
      ST_A_ETST: begin
        cmd = mk(OP_LT, R_T0, R_TOL, R_T0);
        go  = st.cmp ? ST_P_XW : ST_B_PABS;
      end

      // Parabola through the three best points.
      ST_P_XW:  begin cmd = mk(OP_SUB, R_T0, R_X, R_W); go = ST_P_XV; end
      ST_P_XV:  begin cmd = mk(OP_SUB, R_T1, R_X, R_V); go = ST_P_FV; end
      ST_P_FV:  begin cmd = mk(OP_SUB, R_T3, R_FX, R_FV); go = ST_P_R; end
      ST_P_R:   begin cmd = mk(OP_MUL, R_R, R_T0, R_T3); go = ST_P_FW; end
      ST_P_FW:  begin cmd = mk(OP_SUB, R_T3, R_FX, R_FW); go = ST_P_Q; end
      ST_P_Q:   begin cmd = mk(OP_MUL, R_Q, R_T1, R_T3); go = ST_P_XVQ; end
      ST_P_XVQ: begin cmd = mk(OP_MUL, R_T1, R_T1, R_Q); go = ST_P_XWR; end
      ST_P_XWR: begin cmd = mk(OP_MUL, R_T0, R_T0, R_R); go = ST_P_P; end
      ST_P_P:   begin cmd = mk(OP_SUB, R_P, R_T1, R_T0); go = ST_P_QR; end
      ST_P_QR:  begin cmd = mk(OP_SUB, R_Q, R_Q, R_R); go = ST_P_QQ; end
      ST_P_QQ:  begin cmd = mk(OP_ADD, R_Q, R_Q, R_Q); go = ST_P_QPOS; end
      ST_P_QPOS: begin
        cmd = mk(OP_LT, R_T0, R_ZERO, R_Q);
        go  = st.cmp ? ST_P_NEG : ST_P_QABS;
      end
      ST_P_NEG:  begin cmd = mk(OP_SUB, R_P, R_ZERO, R_P); go = ST_P_QABS; end
      ST_P_QABS: begin cmd = mk(OP_ABS, R_Q, R_Q, R_ZERO); go = ST_P_RE; end
      ST_P_RE:   begin cmd = mk(OP_MOV, R_R, R_E, R_ZERO); go = ST_P_ED; end
      ST_P_ED:   begin cmd = mk(OP_MOV, R_E, R_D, R_ZERO); go = ST_B_PABS; end

      // Acceptance tests for the parabolic step.
      ST_B_PABS: begin cmd = mk(OP_ABS, R_T0, R_P, R_ZERO); go = ST_B_QR; end
      ST_B_QR:   begin cmd = mk(OP_MUL, R_T1, R_Q, R_R); go = ST_B_HALF; end
      ST_B_HALF: begin cmd = mk(OP_HALF, R_T1, R_T1, R_ZERO); go = ST_B_QRA; end
      ST_B_QRA:  begin cmd = mk(OP_ABS, R_T1, R_T1, R_ZERO); go = ST_B_T1; end
      ST_B_T1: begin
        cmd = mk(OP_LT, R_T0, R_T0, R_T1);
        go  = st.cmp ? ST_B_SAX : ST_G_SB;
      end
      ST_B_SAX: begin cmd = mk(OP_SUB, R_T0, R_SA, R_X); go = ST_B_MLO; end
      ST_B_MLO: begin cmd = mk(OP_MUL, R_T0, R_Q, R_T0); go = ST_B_T2; end
      ST_B_T2: begin
        cmd = mk(OP_LT, R_T0, R_T0, R_P);
        go  = st.cmp ? ST_B_SBX : ST_G_SB;
      end
      ST_B_SBX: begin cmd = mk(OP_SUB, R_T0, R_SB, R_X); go = ST_B_MHI; end
      ST_B_MHI: begin cmd = mk(OP_MUL, R_T0, R_Q, R_T0); go = ST_B_T3; end
      ST_B_T3: begin
        cmd = mk(OP_LT, R_T0, R_P, R_T0);
        go  = st.cmp ? ST_B_DIV : ST_G_SB;
      end
      ST_B_DIV: begin cmd = mk(OP_DIV, R_D, R_P, R_Q); go = ST_B_U; end
      ST_B_U:   begin cmd = mk(OP_ADD, R_T0, R_X, R_D); go = ST_B_UL; end
      ST_B_UL:  begin cmd = mk(OP_SUB, R_T1, R_T0, R_SA); go = ST_B_T4; end
      ST_B_T4: begin
        cmd = mk(OP_LT, R_T1, R_T1, R_T2);
        go  = st.cmp ? ST_B_SIDE : ST_B_UH;
      end
      ST_B_UH: begin cmd = mk(OP_SUB, R_T1, R_SB, R_T0); go = ST_B_T5; end
      ST_B_T5: begin
        cmd = mk(OP_LT, R_T1, R_T1, R_T2);
        go  = st.cmp ? ST_B_SIDE : ST_C_DABS;
      end
      ST_B_SIDE: begin cmd = mk(OP_LT, R_T0, R_X, R_M); go = ST_B_SEL; end
      ST_B_SEL:  begin cmd = mk(OP_SELNEG, R_D, R_TOL, R_ZERO); go = ST_C_DABS; end

      // Golden-section step into the larger part of the bracket.
      ST_G_SB:   begin cmd = mk(OP_SUB, R_T0, R_SB, R_X); go = ST_G_SA; end
      ST_G_SA:   begin cmd = mk(OP_SUB, R_T1, R_SA, R_X); go = ST_G_SIDE; end
      ST_G_SIDE: begin cmd = mk(OP_LT, R_T0, R_X, R_M); go = ST_G_SEL; end
      ST_G_SEL:  begin cmd = mk(OP_SEL, R_E, R_T0, R_T1); go = ST_G_D; end
      ST_G_D:    begin cmd = mk(OP_MUL, R_D, R_GOLD, R_E); go = ST_C_DABS; end

      // Next point, at least one tolerance away from the best point.
      ST_C_DABS: begin cmd = mk(OP_ABS, R_T0, R_D, R_ZERO); go = ST_C_TST; end
      ST_C_TST: begin
        cmd = mk(OP_LE, R_T0, R_TOL, R_T0);
        go  = st.cmp ? ST_C_UD : ST_C_UP;
      end
      ST_C_UD: begin
        cmd = mk(OP_ADD, R_U, R_X, R_D);
        go  = ST_EMIT;
        if (st.ack) begin
          phase_nxt     = PH_SEARCH;
          emit_done_nxt = 1'b0;
          emit_u_nxt    = 1'b1;
        end
      end
      ST_C_UP:   begin cmd = mk(OP_ADD, R_T1, R_X, R_TOL); go = ST_C_UM; end
      ST_C_UM:   begin cmd = mk(OP_SUB, R_T3, R_X, R_TOL); go = ST_C_SIGN; end
      ST_C_SIGN: begin cmd = mk(OP_LT, R_T0, R_ZERO, R_D); go = ST_C_SEL; end
      ST_C_SEL: begin
        cmd = mk(OP_SEL, R_U, R_T1, R_T3);
        go  = ST_EMIT;
        if (st.ack) begin
          phase_nxt     = PH_SEARCH;
          emit_done_nxt = 1'b0;
          emit_u_nxt    = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.valid && st.ack) state_nxt = go;
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      emit_done_r <= 1'b0;
      emit_u_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      emit_done_r <= emit_done_nxt;
      emit_u_r    <= emit_u_nxt;
    end
  end

endmodule

@@ hdl/brent_scalar_minimizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_scalar_minimizer
// Brent's derivative-free minimiser on an interval; the objective is evaluated
// outside and each request returns the next point to evaluate or done.
//
//   Channel  Direction  Handshake            Payload
//   in_      request    in_valid / in_ready   opcode, func_value
//   out_     result     out_valid / out_ready eval_point, done_res, best_*
//   cfg_     config     cfg_we                cfg_index, cfg_wdata
//
// One request is worked on at a time. Each datapath operation passes through an
// issue and an execute state; a multiplication, and the parabolic division by a
// nonzero divisor, then go on in their own states, the division being a restoring
// divider that yields one quotient bit per cycle.
// Reset is synchronous and needs no clearing pass. A result waits in the
// output register while the next request is already accepted.
// ----------------------------------------------------------------------------
module brent_scalar_minimizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bsm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bsm_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bsm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bsm_pkg::WORD_BITS-1:0]     cfg_wdata
);
  import bsm_pkg::*;

  cmd_t       cmd;
  dp_status_t st;
  emit_t      emit;
  out_item_t  res;
  logic       in_take;
  logic       out_free;
  logic       out_valid_r;
  out_item_t  out_data_r;

  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .st        (st),
    .cmd       (cmd),
    .emit      (emit)
  );

  bsm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_take   (in_take),
    .in_fv     (in_data.func_value),
    .cmd       (cmd),
    .emit      (emit),
    .st        (st),
    .res       (res)
  );

  // Output register decoupling the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (emit.load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
